FILE: hdl/ship_pkg.sv
// shared types and constants for the ship rrip replacement block
package ship_pkg;

    typedef logic [1:0] t_rrpv;
    typedef logic [1:0] t_ctr;

    localparam logic OP_VICTIM = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    localparam t_rrpv RRPV_ZERO = 2'd0;
    localparam t_rrpv RRPV_MID  = 2'd2;
    localparam t_rrpv RRPV_MAX  = 2'd3;

    localparam t_ctr CTR_ZERO  = 2'd0;
    localparam t_ctr CTR_ONE   = 2'd1;
    localparam t_ctr CTR_TWO   = 2'd2;
    localparam t_ctr CTR_MAX   = 2'd3;

    localparam int SIG_SRC_W = 6;

endpackage

FILE: hdl/ship_rrip_replacement.sv
// top level: signature-predicted rrip replacement state and control
//
// Command interface. A word is taken at a clock edge where start is high and
// busy is low. op selects a victim request (one result) or an update (none).
// Set state lives in one row-wide memory, one row per set, each line holding
// its 2-bit re-reference value, stored signature and reuse mark. The reuse
// predictor counters live in a second memory with two read ports.
// A victim request reads the row, ages it and writes it back; o_victim_valid
// is registered from the S_ROW state and busy drops as it rises, so a new
// word can be taken while the result is shown.
// An update reads the row, then the counters of the old and the new
// signature, then writes both memories if the way is below NUM_WAYS; busy
// is high through the writes. The row read and the counter read are registered.
// After reset a clearing pass writes every row and every counter, one
// address a cycle; busy is high during that pass. The receiver cannot stall:
// each result is shown once.
module ship_rrip_replacement #(
    parameter int NUM_SETS          = 2048,
    parameter int NUM_WAYS          = 16,
    parameter int PREDICTOR_ENTRIES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_op,
    input  logic [10:0] i_set_index,
    input  logic [3:0] i_way,
    input  logic       i_hit,
    input  logic [5:0] i_pc_low,
    input  logic [5:0] i_line_addr_low,
    output logic       o_victim_valid,
    output logic [3:0] o_victim_way
);
    import ship_pkg::*;

    localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W  = $clog2(NUM_WAYS);
    localparam int SIG_W  = $clog2(PREDICTOR_ENTRIES);
    localparam int LSIG_W = (SIG_W < SIG_SRC_W) ? SIG_W : SIG_SRC_W;
    localparam int CLR_N  = (NUM_SETS > PREDICTOR_ENTRIES) ? NUM_SETS : PREDICTOR_ENTRIES;
    localparam int CLR_W  = $clog2(CLR_N);

    localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_N - 1);
    localparam logic [CLR_W:0]   CLR_SETS = (CLR_W + 1)'(NUM_SETS);
    localparam logic [CLR_W:0]   CLR_PRED = (CLR_W + 1)'(PREDICTOR_ENTRIES);
    localparam logic [5:0]       WAYS6    = 6'(NUM_WAYS);

    typedef struct packed {
        t_rrpv             rrpv;
        logic [LSIG_W-1:0] sig;
        logic              reused;
    } t_line;

    typedef t_line [NUM_WAYS-1:0] t_row;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_ROW,
        S_PRED
    } t_state;

    // reduce a narrow value modulo a constant by conditional subtraction
    function automatic logic [10:0] fold_mod(input logic [10:0] x, input int n);
        logic [31:0] acc;
        acc = 32'(x);
        for (int j = 10; j >= 0; j--) begin
            if ((n << j) < 2048 && acc >= 32'(n << j)) begin
                acc = acc - 32'(n << j);
            end
        end
        return acc[10:0];
    endfunction

    t_state            r_state;
    logic [CLR_W-1:0]  r_clr_cnt;
    logic              r_victim_valid;
    logic [3:0]        r_victim_way;
    logic              r_op;
    logic              r_hit;
    logic [3:0]        r_way;
    logic [SET_W-1:0]  r_set;
    logic [LSIG_W-1:0] r_new_sig;
    logic [LSIG_W-1:0] r_old_sig;
    logic              r_reused;

    // memories and their registered read data
    t_row              row_mem [NUM_SETS];
    t_ctr              pred_mem [PREDICTOR_ENTRIES];
    t_row              r_row_rd;
    t_ctr              r_pred_a;
    t_ctr              r_pred_b;

    logic [SET_W-1:0]  n_set;
    logic [LSIG_W-1:0] n_new_sig;
    logic [SET_W-1:0]  row_raddr;
    logic              row_we;
    logic [SET_W-1:0]  row_waddr;
    t_row              row_wdata;
    logic [SIG_W-1:0]  pred_raddr_a;
    logic [SIG_W-1:0]  pred_raddr_b;
    logic              pred_we;
    logic [SIG_W-1:0]  pred_waddr;
    t_ctr              pred_wdata;

    logic [WAY_W-1:0]  way_idx;
    logic              way_ok;
    logic              accept;
    t_line             cur_line;
    t_line             new_line;
    t_row              clr_row;
    t_row              aged_row;
    t_rrpv [NUM_WAYS-1:0] row_rrpv;
    t_rrpv [NUM_WAYS-1:0] aged_rrpv;
    logic [3:0]        victim_way;
    t_ctr              ctr_mod;
    t_ctr              ctr_new;
    logic              clr_sets_on;
    logic              clr_pred_on;

    assign accept    = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign n_set     = SET_W'(fold_mod(i_set_index, NUM_SETS));
    assign n_new_sig = LSIG_W'(fold_mod({5'd0, i_pc_low ^ i_line_addr_low}, PREDICTOR_ENTRIES));
    assign way_idx   = WAY_W'(r_way);
    assign way_ok    = ({2'b00, r_way} < WAYS6);
    assign cur_line  = r_row_rd[way_idx];
    assign row_raddr = (r_state == S_IDLE) ? n_set : r_set;

    assign pred_raddr_a = SIG_W'(cur_line.sig);
    assign pred_raddr_b = SIG_W'(r_new_sig);

    assign clr_sets_on = ({1'b0, r_clr_cnt} < CLR_SETS);
    assign clr_pred_on = ({1'b0, r_clr_cnt} < CLR_PRED);

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            row_rrpv[w]       = r_row_rd[w].rrpv;
            aged_row[w]       = r_row_rd[w];
            aged_row[w].rrpv  = aged_rrpv[w];
            clr_row[w].rrpv   = RRPV_MAX;
            clr_row[w].sig    = '0;
            clr_row[w].reused = 1'b0;
        end
    end

    ship_victim_sel #(
        .NUM_WAYS (NUM_WAYS)
    ) u_victim_sel (
        .i_rrpv       (row_rrpv),
        .o_aged       (aged_rrpv),
        .o_victim_way (victim_way)
    );

    // counter update for the old signature, then the new signature's value
    always_comb begin
        if (r_hit) begin
            ctr_mod = (r_pred_a == CTR_MAX) ? r_pred_a : r_pred_a + 2'd1;
        end else if (!r_reused && r_pred_a != CTR_ZERO) begin
            ctr_mod = r_pred_a - 2'd1;
        end else begin
            ctr_mod = r_pred_a;
        end
        // same entry: see the value just updated
        ctr_new = (r_new_sig == r_old_sig) ? ctr_mod : r_pred_b;

        new_line = cur_line;
        if (r_hit) begin
            new_line.rrpv   = RRPV_ZERO;
            new_line.reused = 1'b1;
        end else begin
            new_line.sig    = r_new_sig;
            new_line.reused = 1'b0;
            if (ctr_new == CTR_TWO || ctr_new == CTR_MAX) begin
                new_line.rrpv = RRPV_ZERO;
            end else if (ctr_new == CTR_ONE) begin
                new_line.rrpv = RRPV_MID;
            end else begin
                new_line.rrpv = RRPV_MAX;
            end
        end
    end

    // memory write ports
    always_comb begin
        row_we     = 1'b0;
        row_waddr  = r_set;
        row_wdata  = aged_row;
        pred_we    = 1'b0;
        pred_waddr = SIG_W'(r_old_sig);
        pred_wdata = ctr_mod;
        unique case (r_state)
            S_CLEAR: begin
                row_we     = clr_sets_on;
                row_waddr  = SET_W'(r_clr_cnt);
                row_wdata  = clr_row;
                pred_we    = clr_pred_on;
                pred_waddr = SIG_W'(r_clr_cnt);
                pred_wdata = CTR_ONE;
            end
            S_IDLE: begin
            end
            S_ROW: begin
                row_we = (r_op == OP_VICTIM);
            end
            S_PRED: begin
                row_we    = 1'b1;
                row_wdata = r_row_rd;
                row_wdata[way_idx] = new_line;
                pred_we   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (row_we) begin
            row_mem[row_waddr] <= row_wdata;
        end
        r_row_rd <= row_mem[row_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (pred_we) begin
            pred_mem[pred_waddr] <= pred_wdata;
        end
        r_pred_a <= pred_mem[pred_raddr_a];
        r_pred_b <= pred_mem[pred_raddr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr_cnt      <= '0;
            r_victim_valid <= 1'b0;
        end else begin
            r_victim_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + CLR_W'(1);
                    if (r_clr_cnt == CLR_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_op      <= i_op;
                        r_hit     <= i_hit;
                        r_way     <= i_way;
                        r_set     <= n_set;
                        r_new_sig <= n_new_sig;
                        r_state   <= S_ROW;
                    end
                end
                S_ROW: begin
                    r_old_sig <= cur_line.sig;
                    r_reused  <= cur_line.reused;
                    if (r_op == OP_VICTIM) begin
                        r_victim_valid <= 1'b1;
                        r_victim_way   <= victim_way;
                        r_state        <= S_IDLE;
                    end else if (way_ok) begin
                        r_state <= S_PRED;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_PRED: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_victim_valid = r_victim_valid;
    assign o_victim_way   = r_victim_way;

    a_result_after_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_victim_valid |-> $past(r_state == S_ROW) && r_op == OP_VICTIM)
        else $error("victim strobe without a victim row read");

    a_accept_reads_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> r_state == S_ROW)
        else $error("accepted word did not start a row read");

    a_pred_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRED) |-> $past(r_state == S_ROW) && r_op == OP_UPDATE && way_ok)
        else $error("counter write without a valid update");

endmodule

FILE: hdl/ship_victim_sel.sv
// ages one set row and picks the lowest way at the distant re-reference value
module ship_victim_sel #(
    parameter int NUM_WAYS = 16
) (
    input  ship_pkg::t_rrpv [NUM_WAYS-1:0] i_rrpv,
    output ship_pkg::t_rrpv [NUM_WAYS-1:0] o_aged,
    output logic [3:0]                     o_victim_way
);
    import ship_pkg::*;

    logic  any3;
    logic  any2;
    logic  any1;
    t_rrpv delta;

    // largest value in the row, taken from or-reductions of the compares
    always_comb begin
        any3 = 1'b0;
        any2 = 1'b0;
        any1 = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            any3 = any3 | (i_rrpv[w] == RRPV_MAX);
            any2 = any2 | i_rrpv[w][1];
            any1 = any1 | (i_rrpv[w] != RRPV_ZERO);
        end
        if (any3) begin
            delta = 2'd0;
        end else if (any2) begin
            delta = 2'd1;
        end else if (any1) begin
            delta = 2'd2;
        end else begin
            delta = 2'd3;
        end
    end

    // adding the distance to the top never overflows past the max
    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            o_aged[w] = i_rrpv[w] + delta;
        end
    end

    // priority encoder, lowest way wins
    always_comb begin
        o_victim_way = 4'd0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (o_aged[w] == RRPV_MAX) begin
                o_victim_way = 4'(w);
            end
        end
    end

endmodule
